### rtl/core/assert_macros.svh
// assertion macros for the deframer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge out of reset
`define ASSERT_AT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

### rtl/core/hdlcdf_pkg.sv
package hdlcdf_pkg;

	// field widths
	localparam int LEN_W     = 13;
	localparam int MIN_W     = 7;
	localparam int CFG_IDX_W = 2;

	// hard cap on the frame length, FCS included
	localparam int FRAME_LEN_LIMIT = 4096;
	localparam logic [LEN_W:0] FRAME_LIMIT_EXT = (LEN_W + 1)'(FRAME_LEN_LIMIT);

	// framing constants
	localparam logic [7:0]  FLAG_PATTERN = 8'h7E;
	localparam logic [2:0]  STUFF_RUN    = 3'd5;
	localparam logic [2:0]  FLAG_RUN     = 3'd6;
	localparam logic [2:0]  LAST_BIT_IDX = 3'd7;
	localparam logic [15:0] CRC_POLY     = 16'h8408;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;

	// register reset values
	localparam logic [LEN_W-1:0] MAX_FRAME_RESET = LEN_W'(256);
	localparam logic [MIN_W-1:0] MIN_FRAME_RESET = MIN_W'(16);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME = CFG_IDX_W'(1);

	// result codes
	typedef enum logic [2:0] {
		KIND_DATA    = 3'd0,
		KIND_GOOD    = 3'd1,
		KIND_BAD_FCS = 3'd2,
		KIND_SHORT   = 3'd3,
		KIND_LONG    = 3'd4
	} kind_t;

	// configuration register contents
	typedef struct packed {
		logic [LEN_W-1:0] max_frame_bytes;
		logic [MIN_W-1:0] min_frame_bytes;
	} cfg_t;

	// one result word from the core
	typedef struct packed {
		logic             valid;
		kind_t            kind;
		logic [7:0]       data_byte;
		logic [LEN_W-1:0] frame_bytes;
		logic             last;
	} result_t;

endpackage

### rtl/core/hdlcdf_cfg_regs.sv
module hdlcdf_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hdlcdf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hdlcdf_pkg::LEN_W-1:0]      cfg_data,
	output hdlcdf_pkg::cfg_t                  cfg
);
	import hdlcdf_pkg::*;

	logic [LEN_W-1:0] max_frame_q;
	logic [MIN_W-1:0] min_frame_q;

	// writes always taken
	assign cfg_ready = 1'b1;

	// register file, writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_q <= MAX_FRAME_RESET;
			min_frame_q <= MIN_FRAME_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAX_FRAME: max_frame_q <= cfg_data;
				CFG_MIN_FRAME: min_frame_q <= cfg_data[MIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.max_frame_bytes = max_frame_q;
	assign cfg.min_frame_bytes = min_frame_q;

endmodule

### rtl/core/hdlcdf_core.sv
module hdlcdf_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 bit_in,
	input  hdlcdf_pkg::cfg_t     cfg,
	output hdlcdf_pkg::result_t  res
);
	import hdlcdf_pkg::*;

	// frame state
	logic             synced_q, synced_n;
	logic [7:0]       shift_q, shift_n;
	logic [2:0]       idx_q, idx_n;
	logic [2:0]       ones_q, ones_n;
	logic [15:0]      held_q, held_n;
	logic [1:0]       held_cnt_q, held_cnt_n;
	logic [15:0]      crc_q, crc_n;
	logic [LEN_W-1:0] count_q, count_n;

	logic             restart;
	logic             do_shift;
	logic [7:0]       hunt_shift;
	logic [7:0]       shifted;
	logic [LEN_W-1:0] total;
	logic             is_short;
	logic [LEN_W:0]   limit;
	logic [15:0]      expect_fcs;

	// one byte of reflected crc, lsb first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in;
		for (int i = 0; i < 8; i++) begin
			if (c[0] ^ b[i])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

	// shared terms
	assign hunt_shift = {shift_q[6:0], bit_in};
	assign shifted    = shift_q | (8'(bit_in) << idx_q);
	assign total      = count_q + LEN_W'(held_cnt_q);
	assign is_short   = total < LEN_W'(cfg.min_frame_bytes);
	assign limit      = ({1'b0, cfg.max_frame_bytes} < FRAME_LIMIT_EXT) ?
		{1'b0, cfg.max_frame_bytes} : FRAME_LIMIT_EXT;
	assign expect_fcs = {held_q[7:0], held_q[15:8]};

	// per-bit next state and result
	always_comb begin
		synced_n   = synced_q;
		shift_n    = shift_q;
		idx_n      = idx_q;
		ones_n     = ones_q;
		held_n     = held_q;
		held_cnt_n = held_cnt_q;
		crc_n      = crc_q;
		count_n    = count_q;
		restart    = 1'b0;
		do_shift   = 1'b0;
		res        = '0;
		res.kind   = KIND_DATA;

		if (!synced_q) begin
			// hunting for the opening flag
			shift_n = hunt_shift;
			if (hunt_shift == FLAG_PATTERN) begin
				synced_n = 1'b1;
				restart  = 1'b1;
			end
		end else if (bit_in) begin
			if (ones_q == FLAG_RUN) begin
				// seven ones: abort, back to hunting
				if (total != '0) begin
					res.valid       = 1'b1;
					res.kind        = is_short ? KIND_SHORT : KIND_BAD_FCS;
					res.frame_bytes = count_q;
					res.last        = 1'b1;
				end
				synced_n = 1'b0;
				restart  = 1'b1;
			end else begin
				ones_n   = ones_q + 3'd1;
				do_shift = 1'b1;
			end
		end else if (ones_q == FLAG_RUN) begin
			// closing flag, stays synced for the next frame
			if (total != '0) begin
				res.valid       = 1'b1;
				res.frame_bytes = count_q;
				res.last        = 1'b1;
				if (is_short)
					res.kind = KIND_SHORT;
				else if (idx_q != LAST_BIT_IDX || !held_cnt_q[1])
					res.kind = KIND_BAD_FCS;
				else if (~crc_q == expect_fcs)
					res.kind = KIND_GOOD;
				else
					res.kind = KIND_BAD_FCS;
			end
			restart = 1'b1;
		end else if (ones_q == STUFF_RUN) begin
			// stuffed zero dropped
			ones_n = '0;
		end else begin
			ones_n   = '0;
			do_shift = 1'b1;
		end

		// byte assembly
		if (do_shift) begin
			idx_n = idx_q + 3'd1;
			if (idx_q == LAST_BIT_IDX) begin
				shift_n = '0;
				if ({1'b0, total} + (LEN_W + 1)'(1) > limit) begin
					res.valid       = 1'b1;
					res.kind        = KIND_LONG;
					res.frame_bytes = count_q;
					res.last        = 1'b1;
					synced_n        = 1'b0;
					restart         = 1'b1;
				end else if (held_cnt_q[1]) begin
					crc_n           = crc16_byte(crc_q, held_q[15:8]);
					count_n         = count_q + LEN_W'(1);
					held_n          = {held_q[7:0], shifted};
					res.valid       = 1'b1;
					res.kind        = KIND_DATA;
					res.data_byte   = held_q[15:8];
				end else begin
					held_n     = {held_q[7:0], shifted};
					held_cnt_n = held_cnt_q + 2'd1;
				end
			end else begin
				shift_n = shifted;
			end
		end

		// frame restart
		if (restart) begin
			shift_n    = '0;
			idx_n      = '0;
			ones_n     = '0;
			held_n     = '0;
			held_cnt_n = '0;
			crc_n      = CRC_INIT;
			count_n    = '0;
		end

		if (!step)
			res.valid = 1'b0;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			synced_q   <= 1'b0;
			shift_q    <= '0;
			idx_q      <= '0;
			ones_q     <= '0;
			held_q     <= '0;
			held_cnt_q <= '0;
			crc_q      <= CRC_INIT;
			count_q    <= '0;
		end else if (step) begin
			synced_q   <= synced_n;
			shift_q    <= shift_n;
			idx_q      <= idx_n;
			ones_q     <= ones_n;
			held_q     <= held_n;
			held_cnt_q <= held_cnt_n;
			crc_q      <= crc_n;
			count_q    <= count_n;
		end
	end

endmodule

### rtl/core/hdlc_bit_deframer_fcs.sv
// channel | direction | signals
// in      | sink      | in_valid, in_ready, rx_bit
// out     | source    | out_valid, out_ready, kind, data_byte, frame_bytes, last
// cfg     | sink      | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// one bit word per cycle unless the output stalls: a bit is held in the input register, and its
// result, if any, is registered into the output register when the core steps on that bit
// shift, ones count, held fcs bytes and a whole-byte crc update happen in that same step
// reset is asynchronous: the block hunts for a flag, state and cfg registers take defaults
// cfg writes are always taken
// a stalled output holds the input register, otherwise a bit moves every cycle
`include "assert_macros.svh"

module hdlc_bit_deframer_fcs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              rx_bit,
	output logic                              out_valid,
	input  logic                              out_ready,
	output hdlcdf_pkg::kind_t                 kind,
	output logic [7:0]                        data_byte,
	output logic [hdlcdf_pkg::LEN_W-1:0]      frame_bytes,
	output logic                              last,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hdlcdf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hdlcdf_pkg::LEN_W-1:0]      cfg_data
);
	import hdlcdf_pkg::*;

	cfg_t             cfg;
	result_t          res;
	logic             valid_s1;
	logic             bit_s1;
	logic             advance;
	logic             step;
	logic             out_valid_q;
	kind_t            kind_q;
	logic [7:0]       data_byte_q;
	logic [LEN_W-1:0] frame_bytes_q;
	logic             last_q;

	// configuration registers
	hdlcdf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// handshake between stages
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			bit_s1 <= rx_bit;
	end

	// deframer state and per-bit logic
	hdlcdf_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.bit_in (bit_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= res.valid;
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			kind_q        <= res.kind;
			data_byte_q   <= res.data_byte;
			frame_bytes_q <= res.frame_bytes;
			last_q        <= res.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign data_byte   = data_byte_q;
	assign frame_bytes = frame_bytes_q;
	assign last        = last_q;

	// checks
	`ASSERT_AT(a_stall_blocks_input, clk, arst_n, (out_valid && !out_ready && valid_s1) |-> !in_ready)
	`ASSERT_AT(a_result_needs_bit, clk, arst_n, $rose(out_valid) |-> $past(valid_s1))
	`ASSERT_AT(a_status_len_bound, clk, arst_n, (out_valid && last) |-> ({1'b0, frame_bytes} <= FRAME_LIMIT_EXT))

endmodule

### tb/deframe_checker.sv
`timescale 1ns / 1ps

module deframe_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic                              rx_bit,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  hdlcdf_pkg::kind_t                 kind,
	input  logic [7:0]                        data_byte,
	input  logic [hdlcdf_pkg::LEN_W-1:0]      frame_bytes,
	input  logic                              last,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [hdlcdf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hdlcdf_pkg::LEN_W-1:0]      cfg_data,
	output int                                mismatches,
	output int                                outstanding,
	output int                                n_data,
	output int                                n_good,
	output int                                n_bad,
	output int                                n_short,
	output int                                n_long
);
	import hdlcdf_pkg::*;

	// one predicted result word
	typedef struct packed {
		kind_t            kind;
		logic [7:0]       data_byte;
		logic [LEN_W-1:0] frame_bytes;
		logic             last;
	} frame_word_t;

	frame_word_t pending_words[$];
	int          fails;
	int          tally [0:4];

	// limit registers as last written
	logic [LEN_W-1:0] max_len;
	logic [MIN_W-1:0] min_len;

	// receiver state
	logic             locked;
	logic [7:0]       shreg;
	logic [2:0]       bidx;
	logic [2:0]       ones;
	logic [15:0]      held;
	logic [1:0]       nheld;
	logic [15:0]      fcs_acc;
	logic [LEN_W-1:0] nbytes;

	// reflected crc-16 over one byte, lsb first
	function automatic logic [15:0] fcs_fold(logic [15:0] c, logic [7:0] d);
		for (int i = 0; i < 8; i++) begin
			if (c[0] ^ d[i])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

	task automatic frame_clear();
		shreg   = '0;
		bidx    = '0;
		ones    = '0;
		held    = '0;
		nheld   = '0;
		fcs_acc = CRC_INIT;
		nbytes  = '0;
	endtask

	task automatic post_status(kind_t k);
		frame_word_t w;
		w = '{kind: k, data_byte: 8'h00, frame_bytes: nbytes, last: 1'b1};
		pending_words.push_back(w);
	endtask

	// advance the receiver by one line bit, queue what it produces
	task automatic deframe_bit(logic b);
		int          total;
		int          cap;
		logic [7:0]  octet;
		frame_word_t w;
		// hunting for the opening flag
		if (!locked) begin
			shreg = {shreg[6:0], b};
			if (shreg == FLAG_PATTERN) begin
				locked = 1'b1;
				frame_clear();
			end
			return;
		end
		total = nbytes + nheld;
		if (b) begin
			ones = ones + 1'b1;
			// seven ones abort the frame
			if (ones == 3'd7) begin
				if (total != 0)
					post_status((total < min_len) ? KIND_SHORT : KIND_BAD_FCS);
				locked = 1'b0;
				frame_clear();
				return;
			end
		end else begin
			// closing flag
			if (ones == FLAG_RUN) begin
				if (total != 0) begin
					if (total < min_len)
						post_status(KIND_SHORT);
					else if (bidx != LAST_BIT_IDX || nheld < 2)
						post_status(KIND_BAD_FCS);
					else
						post_status(((~fcs_acc) == {held[7:0], held[15:8]}) ?
							KIND_GOOD : KIND_BAD_FCS);
				end
				frame_clear();
				return;
			end
			// stuffed zero is dropped
			if (ones == STUFF_RUN) begin
				ones = '0;
				return;
			end
			ones = '0;
		end
		shreg[bidx] = b;
		bidx = bidx + 1'b1;
		if (bidx != 0)
			return;
		// a whole byte is in
		octet = shreg;
		shreg = '0;
		cap = (max_len < FRAME_LEN_LIMIT) ? int'(max_len) : FRAME_LEN_LIMIT;
		if (total + 1 > cap) begin
			post_status(KIND_LONG);
			locked = 1'b0;
			frame_clear();
			return;
		end
		if (nheld >= 2) begin
			fcs_acc = fcs_fold(fcs_acc, held[15:8]);
			nbytes = nbytes + 1'b1;
			w = '{kind: KIND_DATA, data_byte: held[15:8], frame_bytes: '0, last: 1'b0};
			pending_words.push_back(w);
		end else begin
			nheld = nheld + 1'b1;
		end
		held = {held[7:0], octet};
	endtask

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			fails++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	task automatic compare_word();
		frame_word_t w;
		if (pending_words.size() == 0) begin
			fails++;
			$error("unexpected word: kind %0d data_byte %0d frame_bytes %0d last %0b",
				kind, data_byte, frame_bytes, last);
			return;
		end
		w = pending_words.pop_front();
		check_field("kind", w.kind, kind);
		check_field("data_byte", w.data_byte, data_byte);
		check_field("frame_bytes", w.frame_bytes, frame_bytes);
		check_field("last", w.last, last);
		tally[w.kind]++;
	endtask

	// watch all three channels at the clock edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_words.delete();
			max_len = MAX_FRAME_RESET;
			min_len = MIN_FRAME_RESET;
			locked  = 1'b0;
			frame_clear();
			fails = 0;
			foreach (tally[i])
				tally[i] = 0;
		end else begin
			if (out_valid && out_ready)
				compare_word();
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_MAX_FRAME)
					max_len = cfg_data;
				else if (cfg_index == CFG_MIN_FRAME)
					min_len = cfg_data[MIN_W-1:0];
			end
			if (in_valid && in_ready)
				deframe_bit(rx_bit);
		end
		mismatches  <= fails;
		outstanding <= pending_words.size();
		n_data      <= tally[KIND_DATA];
		n_good      <= tally[KIND_GOOD];
		n_bad       <= tally[KIND_BAD_FCS];
		n_short     <= tally[KIND_SHORT];
		n_long      <= tally[KIND_LONG];
	end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import hdlcdf_pkg::*;

	localparam int HOLD_CYCLES = 200;
	localparam int QUIET_LIMIT = 2000;
	localparam int SEG_BITS    = 40;

	typedef enum int {
		FLAW_NONE,
		FLAW_FCS,
		FLAW_ALIGN,
		FLAW_ABORT,
		FLAW_BARE
	} flaw_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic                 rx_bit    = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	kind_t                kind;
	logic [7:0]           data_byte;
	logic [LEN_W-1:0]     frame_bytes;
	logic                 last;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LEN_W-1:0]     cfg_data  = '0;

	int mismatches, outstanding;
	int n_data, n_good, n_bad, n_short, n_long;

	// line bits waiting to be offered
	logic line_q[$];
	int   queued_bits   = 0;
	int   tx_ones       = 0;
	bit   frame_open    = 1'b0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   cur_max       = 256;
	int   cur_min       = 16;
	int   hold_asks     = 0;
	int   hold_done     = 0;
	int   hold_left     = 0;
	int   quiet         = 0;
	int   bits_taken    = 0;

	int lim_max [3] = '{3, 4096, 12};
	int lim_min [3] = '{3, 3, 4};
	int send_pct [3] = '{30, 54, 0};
	int recv_pct [3] = '{54, 30, 0};

	hdlc_bit_deframer_fcs u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_bit      (rx_bit),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.data_byte   (data_byte),
		.frame_bytes (frame_bytes),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	deframe_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_bit      (rx_bit),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.data_byte   (data_byte),
		.frame_bytes (frame_bytes),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.n_data      (n_data),
		.n_good      (n_good),
		.n_bad       (n_bad),
		.n_short     (n_short),
		.n_long      (n_long)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// bit sender: offer the next word, hold it until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_bit   <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (line_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				rx_bit   <= line_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver with random stalls and a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 0;
		end else if (hold_done != hold_asks) begin
			hold_done <= hold_asks;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles with no word moving on any channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet <= 0;
		end else begin
			if (in_valid && in_ready)
				bits_taken <= bits_taken + 1;
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
				quiet <= 0;
			end else if (quiet == QUIET_LIMIT) begin
				$error("no word moved for %0d cycles, %0d results still due",
					quiet, outstanding);
				$display("== FAIL ==");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	function automatic logic [15:0] fcs_step(logic [15:0] c, logic [7:0] d);
		for (int i = 0; i < 8; i++) begin
			if (c[0] ^ d[i])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

	// payload bytes leaning toward runs of ones and flag look-alikes
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'hFF;
			1: return 8'h00;
			2: return FLAG_PATTERN;
			3: return 8'hF8;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// payload length near the current minimum, or near the maximum capped at 8
	function automatic int pick_len();
		int r;
		int n;
		int top_n;
		top_n = (cur_max < 8) ? cur_max : 8;
		r = $urandom_range(0, 9);
		if (r < 2)
			n = $urandom_range(0, cur_min);
		else if (r < 4)
			n = top_n - 3 + $urandom_range(0, 2);
		else
			n = cur_min - 2 + $urandom_range(0, 3);
		return (n < 0) ? 0 : n;
	endfunction

	function automatic flaw_t pick_flaw();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12)
			return FLAW_NONE;
		else if (r < 15)
			return FLAW_FCS;
		else if (r < 17)
			return FLAW_ALIGN;
		else if (r < 19)
			return FLAW_ABORT;
		return FLAW_BARE;
	endfunction

	task automatic put_raw(logic b);
		line_q.push_back(b);
		queued_bits++;
	endtask

	task automatic put_flag();
		for (int i = 7; i >= 0; i--)
			put_raw(FLAG_PATTERN[i]);
		tx_ones = 0;
		frame_open = 1'b1;
	endtask

	// data bit with a zero inserted after five ones
	task automatic put_bit(logic b);
		put_raw(b);
		if (b) begin
			tx_ones++;
			if (tx_ones == STUFF_RUN) begin
				put_raw(1'b0);
				tx_ones = 0;
			end
		end else begin
			tx_ones = 0;
		end
	endtask

	task automatic put_byte(logic [7:0] v);
		for (int i = 0; i < 8; i++)
			put_bit(v[i]);
	endtask

	task automatic noise(int k);
		repeat (k) put_raw($urandom_range(0, 1));
		tx_ones = 0;
		frame_open = 1'b0;
	endtask

	// one frame: n payload bytes, fcs low byte first, then the chosen flaw;
	// cut is the byte count sent before an abort, negative for random
	task automatic send_frame(int n, flaw_t flaw, int cut);
		logic [7:0]  octets[$];
		logic [15:0] acc;
		int          stop;
		acc = CRC_INIT;
		for (int i = 0; i < n; i++) begin
			octets.push_back(pick_byte());
			acc = fcs_step(acc, octets[i]);
		end
		acc = ~acc;
		if (flaw == FLAW_FCS)
			acc[$urandom_range(0, 15)] ^= 1'b1;
		if (flaw != FLAW_BARE) begin
			octets.push_back(acc[7:0]);
			octets.push_back(acc[15:8]);
		end
		stop = octets.size();
		if (flaw == FLAW_ABORT)
			stop = (cut < 0) ? $urandom_range(0, stop) : cut;
		// a closing flag may double as the next opening flag
		if (!frame_open || $urandom_range(0, 1) == 0)
			put_flag();
		for (int i = 0; i < stop; i++)
			put_byte(octets[i]);
		if (flaw == FLAW_ABORT) begin
			repeat (7 + $urandom_range(0, 4)) put_raw(1'b1);
			tx_ones = 0;
			frame_open = 1'b0;
		end else begin
			if (flaw == FLAW_ALIGN)
				repeat ($urandom_range(1, 7)) put_bit($urandom_range(0, 1));
			put_flag();
		end
	endtask

	// stop sending until every expected result is out, then let the pipe empty
	task automatic settle();
		while (line_q.size() != 0 || in_valid)
			@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_limits(int mx, int mn);
		settle();
		write_reg(CFG_MAX_FRAME, LEN_W'(mx));
		write_reg(CFG_MIN_FRAME, LEN_W'(mn));
		cur_max = mx;
		cur_min = mn;
		@(negedge clk);
	endtask

	task automatic run_frames(int budget);
		int start;
		start = queued_bits;
		while (queued_bits - start < budget) begin
			if ($urandom_range(0, 9) == 0)
				noise($urandom_range(1, 24));
			send_frame(pick_len(), pick_flaw(), -1);
			while (line_q.size() > 32)
				@(negedge clk);
		end
	endtask

	initial begin
		int total_fail;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed frames at the reset limits
		send_idle_pct = send_pct[0];
		recv_idle_pct = recv_pct[0];
		noise(8);
		put_flag();
		put_flag();
		send_frame(1, FLAW_NONE, -1);
		send_frame(20, FLAW_ABORT, 0);
		send_frame(20, FLAW_ABORT, 3);

		// zero length limit ends on the first byte
		set_limits(0, 0);
		send_frame(2, FLAW_NONE, -1);

		// one-byte frame with no fcs, and an empty payload with a valid fcs
		set_limits(4096, 1);
		send_frame(1, FLAW_BARE, -1);
		send_frame(0, FLAW_NONE, -1);

		// random frames over the idle mixes and limit settings
		for (int m = 0; m < 3; m++) begin
			send_idle_pct = send_pct[m];
			recv_idle_pct = recv_pct[m];
			set_limits(lim_max[m], lim_min[m]);
			if (m == 1) begin
				hold_asks++;
				send_frame(4, FLAW_NONE, -1);
			end
			run_frames(SEG_BITS);
		end

		// drain
		while (line_q.size() != 0 || in_valid || outstanding != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		total_fail = mismatches;
		if (outstanding != 0) begin
			$error("%0d expected results never arrived", outstanding);
			total_fail++;
		end
		$display("covered %0d line bits: %0d payload bytes, %0d good, %0d bad fcs,",
			bits_taken, n_data, n_good, n_bad);
		$display("%0d short, %0d long; limits 0 to 4096, minimum 0 to 16, stalls and a hold-off",
			n_short, n_long);
		if (total_fail == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
